FILE: rtl/siphash_pkg.sv
// ----------------------------------------------------------------------------
// siphash_pkg
// Shared types, constants and the SipRound function for the SipHash-2-4 block.
// ----------------------------------------------------------------------------
package siphash_pkg;

  typedef logic [63:0] lane_t;

  typedef struct packed {
    lane_t v0;
    lane_t v1;
    lane_t v2;
    lane_t v3;
  } lanes_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // accept a word: start or continue a message
    logic round;       // apply one SipRound to the lanes
    logic end_absorb;  // xor the current block into lane 0 after the round
    logic reabsorb;    // start absorbing the final block after this round
    logic mark;        // xor the finalisation mark into lane 2
    logic capture;     // register the hash of the rounded lanes
  } dp_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS1,
    ST_ABS2,
    ST_FIN
  } state_t;

  typedef enum logic {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_index_t;

  localparam lane_t INIT_ZERO  = 64'h736f6d6570736575;
  localparam lane_t INIT_ONE   = 64'h646f72616e646f6d;
  localparam lane_t INIT_TWO   = 64'h6c7967656e657261;
  localparam lane_t INIT_THREE = 64'h7465646279746573;
  localparam lane_t FINAL_MARK = 64'h00000000000000ff;

  localparam logic [3:0] FULL_BYTES = 4'd8;

  function automatic lane_t rotl(input lane_t x, input int unsigned n);
    rotl = (x << n) | (x >> (64 - n));
  endfunction

  // One SipRound: four add-rotate-xor steps over the four lanes.
  function automatic lanes_t sip_round(input lanes_t s);
    lanes_t r;
    r = s;
    r.v0 = r.v0 + r.v1;
    r.v1 = rotl(r.v1, 13) ^ r.v0;
    r.v0 = rotl(r.v0, 32);
    r.v2 = r.v2 + r.v3;
    r.v3 = rotl(r.v3, 16) ^ r.v2;
    r.v0 = r.v0 + r.v3;
    r.v3 = rotl(r.v3, 21) ^ r.v0;
    r.v2 = r.v2 + r.v1;
    r.v1 = rotl(r.v1, 17) ^ r.v2;
    r.v2 = rotl(r.v2, 32);
    return r;
  endfunction

endpackage

FILE: rtl/siphash_dp.sv
// ----------------------------------------------------------------------------
// siphash_dp
// Datapath: key registers, the four lanes, block registers, the shared round
// unit and the output hash register.
// ----------------------------------------------------------------------------
module siphash_dp import siphash_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  input  dp_cmd_t     cmd,
  output logic [63:0] hash_value
);

  lane_t      key_low;
  lane_t      key_high;
  lanes_t     lanes;
  lane_t      block;
  lane_t      fin_blk;
  logic [7:0] length;
  logic       open;
  logic [63:0] hash;

  lanes_t     start_lanes;
  logic [7:0] start_length;
  logic       full;
  logic [3:0] add_bytes;
  logic [7:0] length_next;
  lane_t      tail;
  lane_t      fin_value;
  lane_t      first_block;
  lanes_t     rounded;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (open) begin
      start_lanes  = lanes;
      start_length = length;
    end else begin
      start_lanes.v0 = key_low ^ INIT_ZERO;
      start_lanes.v1 = key_high ^ INIT_ONE;
      start_lanes.v2 = key_low ^ INIT_TWO;
      start_lanes.v3 = key_high ^ INIT_THREE;
      start_length   = '0;
    end
    // A count above eight saturates; a non-last word always adds eight bytes.
    full      = !last_word || byte_count[3];
    add_bytes = full ? FULL_BYTES : byte_count;
    length_next = start_length + {4'b0000, add_bytes};
    for (int j = 0; j < 8; j++) begin
      tail[8*j +: 8] = (!full && (j < int'(byte_count[2:0]))) ? data_word[8*j +: 8] : 8'h00;
    end
    fin_value   = {length_next, tail[55:0]};
    first_block = full ? data_word : fin_value;

    rounded = sip_round(lanes);
    if (cmd.end_absorb) begin
      rounded.v0 = rounded.v0 ^ block;
    end
    if (cmd.mark) begin
      rounded.v2 = rounded.v2 ^ FINAL_MARK;
    end
    if (cmd.reabsorb) begin
      rounded.v3 = rounded.v3 ^ fin_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open   <= 1'b0;
      length <= '0;
    end else if (cmd.load) begin
      open   <= !last_word;
      length <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lanes    <= {start_lanes.v0, start_lanes.v1, start_lanes.v2,
                   start_lanes.v3 ^ first_block};
      block    <= first_block;
      fin_blk  <= fin_value;
    end else if (cmd.round) begin
      lanes <= rounded;
      if (cmd.reabsorb) begin
        block <= fin_blk;
      end
    end
    if (cmd.capture) begin
      hash <= rounded.v0 ^ rounded.v1 ^ rounded.v2 ^ rounded.v3;
    end
  end

  assign hash_value = hash;

endmodule

FILE: rtl/siphash_ctrl.sv
// ----------------------------------------------------------------------------
// siphash_ctrl
// Controller: sequences the compression and finalisation rounds and owns the
// handshake of both channels.
// ----------------------------------------------------------------------------
module siphash_ctrl import siphash_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    word_valid,
  input  logic    last_word,
  input  logic    full_last,
  output logic    word_stall,
  output logic    hash_valid,
  input  logic    hash_stall,
  output dp_cmd_t cmd
);

  state_t     state;
  state_t     state_next;
  logic       is_last;
  logic       need_two;
  logic [1:0] fin_count;
  logic       valid;
  logic       out_busy;

  assign out_busy   = valid && hash_stall;
  assign word_stall = (state != ST_IDLE);
  assign hash_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (word_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ABS1;
        end
      end
      ST_ABS1: begin
        cmd.round  = 1'b1;
        state_next = ST_ABS2;
      end
      ST_ABS2: begin
        cmd.round      = 1'b1;
        cmd.end_absorb = 1'b1;
        if (need_two) begin
          cmd.reabsorb = 1'b1;
          state_next   = ST_ABS1;
        end else if (is_last) begin
          cmd.mark   = 1'b1;
          state_next = ST_FIN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (fin_count != 2'd3) begin
          cmd.round = 1'b1;
        end else if (!out_busy) begin
          cmd.round   = 1'b1;
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_last   <= 1'b0;
      need_two  <= 1'b0;
      fin_count <= '0;
      valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        is_last  <= last_word;
        need_two <= last_word && full_last;
      end else if (cmd.reabsorb) begin
        need_two <= 1'b0;
      end
      if (cmd.mark) begin
        fin_count <= '0;
      end else if (state == ST_FIN && cmd.round) begin
        fin_count <= fin_count + 2'd1;
      end
      if (cmd.capture) begin
        valid <= 1'b1;
      end else if (!hash_stall) begin
        valid <= 1'b0;
      end
    end
  end

  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> !out_busy) else $error("hash overwritten while held");

  a_capture_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> hash_valid) else $error("captured hash not presented");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_ABS1)) else $error("accepted word not absorbed");

  a_fin_single: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (!need_two && is_last)) else $error("finalising a non-last word");

endmodule

FILE: rtl/siphash_2_4_keyed_hash.sv
// ----------------------------------------------------------------------------
// siphash_2_4_keyed_hash
// Keyed SipHash-2-4 over a message streamed as 64-bit little-endian words.
// ----------------------------------------------------------------------------
// Usage:
// Message words arrive on the word channel (data_word, byte_count, last_word
// with word_valid and word_stall). An item is taken when word_valid is high
// and word_stall is low. The word with last_word set ends the message and
// carries 0 to 8 valid bytes; counts above eight are treated as eight.
// One 64-bit hash per message leaves on the hash channel (hash_value with
// hash_valid and hash_stall).
// Every word is absorbed by one shared SipRound unit, one round per cycle
// unless a stalled hash holds the final round: a non-last word is taken and
// gets two rounds; a last word then gets four finalisation rounds, a full
// one two more first; hash_valid rises on the cycle after the final round.
// The key halves are written through cfg_write, cfg_index and cfg_data while
// the block is idle; a new key applies from the next message start.
// Reset clears the keys, the message state and hash_valid. A held result sits
// in its own output register, so the next message can be taken and absorbed
// while the receiver stalls; only the final round of the next message waits.
// ----------------------------------------------------------------------------
module siphash_2_4_keyed_hash import siphash_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        word_valid,
  output logic        word_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  output logic        hash_valid,
  input  logic        hash_stall,
  output logic [63:0] hash_value
);

  dp_cmd_t cmd;

  // The controller only needs to know whether a last word is a full block,
  // which is the case for any count of eight or more.
  siphash_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .last_word  (last_word),
    .full_last  (byte_count[3]),
    .word_stall (word_stall),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .cmd        (cmd)
  );

  siphash_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last_word  (last_word),
    .cmd        (cmd),
    .hash_value (hash_value)
  );

endmodule
